// ===== hw/rtl/mmlp_pkg.sv =====
// Package for the memory-map line parser: widths, character codes,
// parse phase type and helper functions. No dependencies.
package mmlp_pkg;

    localparam int MAX_DIGITS     = 16;
    localparam int COUNT_BITS     = 16;
    localparam int ADDR_BITS      = 64;
    localparam int BYTE_BITS      = 8;
    localparam int PERM_BITS      = 6;
    localparam int COUNT_OUT_BITS = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int DIGIT_CNT_BITS = $clog2(MAX_DIGITS + 1);

    typedef logic [ADDR_BITS-1:0]      addr_t;
    typedef logic [BYTE_BITS-1:0]      byte_t;
    typedef logic [PERM_BITS-1:0]      perm_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [COUNT_OUT_BITS-1:0] count_out_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [DIGIT_CNT_BITS-1:0] digit_cnt_t;

    localparam cfg_index_t REG_STACK_POINTER = cfg_index_t'(0);
    localparam cfg_index_t REG_HEAP_START    = cfg_index_t'(1);

    localparam byte_t CH_ZERO    = 8'd48;
    localparam byte_t CH_NINE    = 8'd57;
    localparam byte_t CH_A       = 8'd97;
    localparam byte_t CH_Z       = 8'd122;
    localparam byte_t CH_NEWLINE = 8'd10;
    localparam byte_t CH_R       = 8'd114;
    localparam byte_t CH_W       = 8'd119;
    localparam byte_t CH_X       = 8'd120;
    localparam byte_t CH_P       = 8'd112;

    localparam perm_t FLAG_HEAP  = perm_t'(16);
    localparam perm_t FLAG_STACK = perm_t'(32);

    localparam count_t     COUNT_MAX      = {COUNT_BITS{1'b1}};
    localparam digit_cnt_t DIGIT_LAST     = digit_cnt_t'(MAX_DIGITS - 1);

    typedef enum logic [3:0] {
        PH_LOW   = 4'b0001,
        PH_HIGH  = 4'b0010,
        PH_PERMS = 4'b0100,
        PH_SKIP  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic stack_hit;
        logic heap_hit;
    } range_hit_t;

    function automatic byte_t perm_letter(input logic [1:0] idx);
        byte_t letter;
        case (idx)
            2'd0:    letter = CH_R;
            2'd1:    letter = CH_W;
            2'd2:    letter = CH_X;
            default: letter = CH_P;
        endcase
        return letter;
    endfunction

endpackage

// ===== hw/rtl/mmlp_in_if.sv =====
// Input channel of the memory-map line parser: one text byte or end flag per word.
// Depends on mmlp_pkg.
interface mmlp_in_if;
    logic                  valid;
    logic                  ready;
    mmlp_pkg::byte_t       text_byte;
    logic                  end_of_input;

    modport source (output valid, output text_byte, output end_of_input, input ready);
    modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

// ===== hw/rtl/mmlp_out_if.sv =====
// Result channel of the memory-map line parser: one entry or end marker per word.
// Depends on mmlp_pkg.
interface mmlp_out_if;
    logic                   valid;
    logic                   ready;
    mmlp_pkg::addr_t        range_low;
    mmlp_pkg::addr_t        range_high;
    mmlp_pkg::perm_t        permissions;
    logic                   is_end;
    mmlp_pkg::count_out_t   entry_count;

    modport source (output valid, output range_low, output range_high,
                    output permissions, output is_end, output entry_count, input ready);
    modport sink   (input valid, input range_low, input range_high,
                    input permissions, input is_end, input entry_count, output ready);
endinterface

// ===== hw/rtl/mmlp_cfg_if.sv =====
// Configuration write channel of the memory-map line parser.
// Depends on mmlp_pkg.
interface mmlp_cfg_if;
    logic                   valid;
    logic                   ready;
    mmlp_pkg::cfg_index_t   index;
    mmlp_pkg::addr_t        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mmlp_range_check.sv =====
// Stack and heap containment test of one parsed address range.
// Depends on mmlp_pkg.
module mmlp_range_check (
    input  mmlp_pkg::addr_t      range_low,
    input  mmlp_pkg::addr_t      range_high,
    input  mmlp_pkg::addr_t      stack_pointer,
    input  mmlp_pkg::addr_t      heap_start,
    output mmlp_pkg::range_hit_t hit
);
    import mmlp_pkg::*;

    always_comb
    begin
        hit.stack_hit = (stack_pointer >= range_low) && (stack_pointer <= range_high);
        hit.heap_hit  = !hit.stack_hit &&
                        (heap_start >= range_low) && (heap_start <= range_high);
    end
endmodule

// ===== hw/rtl/memory_map_line_parser_core.sv =====
// Memory-map line parser top level: byte-wide parse state and result register.
// Depends on mmlp_pkg, mmlp_in_if, mmlp_out_if, mmlp_cfg_if, mmlp_range_check.
// Output: a result is on the output in the cycle after the newline or end word.
// Throughput: one text byte per cycle; the single output register stalls input
// only while a result waits and the sink holds ready low.
// Reset: asynchronous, clears the parse phase, counters, parse and config registers and output valid.
module memory_map_line_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    mmlp_in_if.sink    item_in,
    mmlp_out_if.source item_out,
    mmlp_cfg_if.sink   cfg
);
    import mmlp_pkg::*;

    phase_t      phase_reg, phase_next;
    addr_t       acc_reg, acc_next;
    digit_cnt_t  digit_cnt_reg, digit_cnt_next;
    addr_t       low_reg, low_next;
    addr_t       high_reg, high_next;
    logic [3:0]  perm_bits_reg, perm_bits_next;
    logic [1:0]  perm_idx_reg, perm_idx_next;
    count_t      entries_reg, entries_next;
    logic        finished_reg, finished_next;
    addr_t       stack_reg;
    addr_t       heap_reg;

    logic        out_valid_reg, out_valid_next;
    addr_t       out_low_reg, out_low_next;
    addr_t       out_high_reg, out_high_next;
    perm_t       out_perm_reg, out_perm_next;
    logic        out_end_reg, out_end_next;
    count_out_t  out_count_reg, out_count_next;

    logic        accept;
    logic        is_digit;
    logic [5:0]  digit_val;
    byte_t       c;
    addr_t       acc_shifted;
    range_hit_t  hit;

    assign cfg.ready     = 1'b1;
    assign item_in.ready = !out_valid_reg || item_out.ready;
    assign accept        = item_in.valid && item_in.ready;
    assign c             = item_in.text_byte;

    mmlp_range_check u_range_check (
        .range_low     (low_reg),
        .range_high    (high_reg),
        .stack_pointer (stack_reg),
        .heap_start    (heap_reg),
        .hit           (hit)
    );

    always_comb
    begin
        is_digit  = 1'b0;
        digit_val = 6'd0;
        if (c inside {[CH_ZERO:CH_NINE]})
        begin
            is_digit  = 1'b1;
            digit_val = 6'(c - CH_ZERO);
        end
        else if (c inside {[CH_A:CH_Z]})
        begin
            is_digit  = 1'b1;
            digit_val = 6'(c - CH_A + 8'd10);
        end
        acc_shifted = {acc_reg[ADDR_BITS-5:0], 4'b0000} + ADDR_BITS'(digit_val);
    end

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        digit_cnt_next = digit_cnt_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        perm_bits_next = perm_bits_reg;
        perm_idx_next  = perm_idx_reg;
        entries_next   = entries_reg;
        finished_next  = finished_reg;

        out_valid_next = out_valid_reg && !item_out.ready;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;
        out_perm_next  = out_perm_reg;
        out_end_next   = out_end_reg;
        out_count_next = out_count_reg;

        if (accept && !finished_reg)
        begin
            if (item_in.end_of_input)
            begin
                finished_next  = 1'b1;
                out_valid_next = 1'b1;
                out_low_next   = '0;
                out_high_next  = '0;
                out_perm_next  = '0;
                out_end_next   = 1'b1;
                out_count_next = COUNT_OUT_BITS'(entries_reg);
            end
            else
            begin
                case (phase_reg)
                    PH_LOW, PH_HIGH:
                    begin
                        if (is_digit && digit_cnt_reg != DIGIT_LAST)
                        begin
                            acc_next       = acc_shifted;
                            digit_cnt_next = digit_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            if (phase_reg == PH_LOW)
                            begin
                                low_next   = is_digit ? acc_shifted : acc_reg;
                                phase_next = PH_HIGH;
                            end
                            else
                            begin
                                high_next      = is_digit ? acc_shifted : acc_reg;
                                phase_next     = PH_PERMS;
                                perm_bits_next = '0;
                                perm_idx_next  = '0;
                            end
                            acc_next       = '0;
                            digit_cnt_next = '0;
                        end
                    end
                    PH_PERMS:
                    begin
                        if (c == perm_letter(perm_idx_reg))
                            perm_bits_next = perm_bits_reg | (4'b0001 << perm_idx_reg);
                        perm_idx_next = perm_idx_reg + 1'b1;
                        if (perm_idx_reg == 2'd3)
                            phase_next = PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        if (c == CH_NEWLINE)
                        begin
                            if (entries_reg != COUNT_MAX)
                                entries_next = entries_reg + 1'b1;
                            out_valid_next = 1'b1;
                            out_low_next   = low_reg;
                            out_high_next  = high_reg;
                            out_perm_next  = PERM_BITS'(perm_bits_reg)
                                           | (hit.stack_hit ? FLAG_STACK : '0)
                                           | (hit.heap_hit  ? FLAG_HEAP  : '0);
                            out_end_next   = 1'b0;
                            out_count_next = COUNT_OUT_BITS'(entries_next);
                            phase_next     = PH_LOW;
                            acc_next       = '0;
                            digit_cnt_next = '0;
                            perm_bits_next = '0;
                            perm_idx_next  = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LOW;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LOW;
            acc_reg       <= '0;
            digit_cnt_reg <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            perm_bits_reg <= '0;
            perm_idx_reg  <= '0;
            entries_reg   <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stack_reg     <= '0;
            heap_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            digit_cnt_reg <= digit_cnt_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            perm_bits_reg <= perm_bits_next;
            perm_idx_reg  <= perm_idx_next;
            entries_reg   <= entries_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_STACK_POINTER)
                    stack_reg <= cfg.data;
                else if (cfg.index == REG_HEAP_START)
                    heap_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_low_reg   <= out_low_next;
        out_high_reg  <= out_high_next;
        out_perm_reg  <= out_perm_next;
        out_end_reg   <= out_end_next;
        out_count_reg <= out_count_next;
    end

    assign item_out.valid       = out_valid_reg;
    assign item_out.range_low   = out_low_reg;
    assign item_out.range_high  = out_high_reg;
    assign item_out.permissions = out_perm_reg;
    assign item_out.is_end      = out_end_reg;
    assign item_out.entry_count = out_count_reg;
endmodule
